// ----- rtl/core/midi_running_status_parser_assert.svh -----
// Assertion macros shared by the MIDI running-status parser modules.
`ifndef MIDI_RUNNING_STATUS_PARSER_ASSERT_SVH
`define MIDI_RUNNING_STATUS_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge while reset is released.
`define MRSP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("mrsp assertion failed");

// Check a property on every rising edge, reset included.
`define MRSP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("mrsp assertion failed");

`else

`define MRSP_ASSERT(lbl, clk, rstn, prop)
`define MRSP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/core/mrsp_pkg.sv -----
// Package: types and constants for the MIDI running-status parser.
`default_nettype none

package mrsp_pkg;

    localparam logic [7:0] MIDI_REALTIME_FIRST = 8'hF8;
    localparam logic [7:0] MIDI_SYSTEM_FIRST   = 8'hF0;
    localparam logic [3:0] MIDI_PROGRAM_CHANGE = 4'hC;
    localparam logic [3:0] MIDI_CHAN_PRESSURE  = 4'hD;
    localparam logic [7:0] MIDI_NO_STATUS      = 8'h00;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DATA_W = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] status_byte;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
    } mrsp_msg_t;

    typedef struct packed {
        logic      valid;
        mrsp_msg_t msg;
    } mrsp_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/midi_running_status_parser.sv -----
// Top level of the MIDI running-status parser.
// Takes one raw MIDI byte per transaction and emits one complete channel-voice
// message (status, first data, second data) once all its data bytes have come
// in; realtime bytes are ignored, system bytes cancel running status, and
// one-data-byte messages carry a zero second data byte. The parser state
// updates in the accepting cycle; a completed message is registered in the
// output register, or in the skid register while the m_ channel is stalled.
// A two-entry result buffer keeps s_ready high while one message waits on a
// stalled m_ channel; s_ready drops only when two messages are waiting.
`default_nettype none

module midi_running_status_parser (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mrsp_pkg::BYTE_W-1:0] s_midi_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mrsp_pkg::BYTE_W-1:0]      m_status_byte,
    output logic [mrsp_pkg::DATA_W-1:0]      m_first_data,
    output logic [mrsp_pkg::DATA_W-1:0]      m_second_data
);
    import mrsp_pkg::*;

    logic         s_accept;
    mrsp_result_t parse_result;
    mrsp_msg_t    out_msg;

    assign s_accept = s_valid && s_ready;

    mrsp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_accept),
        .byte_data  (s_midi_byte),
        .result     (parse_result)
    );

    mrsp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (parse_result),
        .push_ready (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_msg    (out_msg)
    );

    assign m_status_byte = out_msg.status_byte;
    assign m_first_data  = out_msg.first_data;
    assign m_second_data = out_msg.second_data;

endmodule

`default_nettype wire

// ----- rtl/core/mrsp_parser.sv -----
// Running-status tracking and message assembly for one byte per cycle while byte_valid is high.
`default_nettype none

module mrsp_parser (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     byte_valid,
    input  wire logic [mrsp_pkg::BYTE_W-1:0] byte_data,
    output mrsp_pkg::mrsp_result_t        result
);
    import mrsp_pkg::*;

    `include "midi_running_status_parser_assert.svh"

    logic [BYTE_W-1:0] running_status_reg, running_status_next;
    logic [1:0]        bytes_needed_reg, bytes_needed_next;
    logic [1:0]        bytes_received_reg, bytes_received_next;
    logic [DATA_W-1:0] data0_reg, data0_next;
    logic [DATA_W-1:0] data1_reg, data1_next;
    logic [1:0]        received_count;
    logic [3:0]        kind;

    assign kind = byte_data[7:4];

    always_comb begin
        running_status_next = running_status_reg;
        bytes_needed_next   = bytes_needed_reg;
        bytes_received_next = bytes_received_reg;
        data0_next          = data0_reg;
        data1_next          = data1_reg;
        received_count      = bytes_received_reg;
        result              = '0;
        if (byte_valid) begin
            if (byte_data >= MIDI_REALTIME_FIRST) begin
                // realtime: leave everything untouched
            end else if (byte_data[7]) begin
                if (byte_data >= MIDI_SYSTEM_FIRST) begin
                    running_status_next = MIDI_NO_STATUS;
                    bytes_needed_next   = 2'd0;
                    bytes_received_next = 2'd0;
                end else begin
                    running_status_next = byte_data;
                    bytes_needed_next   = (kind == MIDI_PROGRAM_CHANGE ||
                                           kind == MIDI_CHAN_PRESSURE) ? 2'd1 : 2'd2;
                    bytes_received_next = 2'd0;
                end
            end else if (running_status_reg != MIDI_NO_STATUS) begin
                if (bytes_received_reg < 2'd2) begin
                    if (bytes_received_reg[0]) begin
                        data1_next = byte_data[DATA_W-1:0];
                    end else begin
                        data0_next = byte_data[DATA_W-1:0];
                    end
                    received_count = bytes_received_reg + 2'd1;
                end
                bytes_received_next = received_count;
                if (received_count >= bytes_needed_reg) begin
                    result.valid           = 1'b1;
                    result.msg.status_byte = running_status_reg;
                    result.msg.first_data  = data0_next;
                    result.msg.second_data = (bytes_needed_reg > 2'd1) ? data1_next : '0;
                    bytes_received_next    = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_status_reg <= MIDI_NO_STATUS;
            bytes_needed_reg   <= 2'd0;
            bytes_received_reg <= 2'd0;
        end else begin
            running_status_reg <= running_status_next;
            bytes_needed_reg   <= bytes_needed_next;
            bytes_received_reg <= bytes_received_next;
        end
    end

    // data bytes are stored as they arrive; the last one is emitted straight from the input byte
    always_ff @(posedge aclk) begin
        data0_reg <= data0_next;
        data1_reg <= data1_next;
    end

    `MRSP_ASSERT(a_no_status_idle, aclk, aresetn, (running_status_reg == MIDI_NO_STATUS) |-> (bytes_needed_reg == 2'd0 && bytes_received_reg == 2'd0))
    `MRSP_ASSERT(a_partial_below_need, aclk, aresetn, (running_status_reg != MIDI_NO_STATUS) |-> (bytes_received_reg < bytes_needed_reg))
    `MRSP_ASSERT(a_emit_channel_status, aclk, aresetn, result.valid |-> (result.msg.status_byte[7] && result.msg.status_byte < MIDI_SYSTEM_FIRST))
    `MRSP_ASSERT(a_short_msg_zero, aclk, aresetn, (result.valid && bytes_needed_reg == 2'd1) |-> (result.msg.second_data == '0))

endmodule

`default_nettype wire

// ----- rtl/core/mrsp_out_buf.sv -----
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module mrsp_out_buf (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mrsp_pkg::mrsp_result_t push,
    output logic                       push_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output mrsp_pkg::mrsp_msg_t        out_msg
);
    import mrsp_pkg::*;

    `include "midi_running_status_parser_assert.svh"

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    mrsp_msg_t out_msg_reg, out_msg_next;
    mrsp_msg_t skid_msg_reg, skid_msg_next;
    logic      pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_msg    = out_msg_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_msg_next    = out_msg_reg;
        skid_valid_next = skid_valid_reg;
        skid_msg_next   = skid_msg_reg;
        if (!out_valid_reg || pop) begin
            // advance: skid first, then the new transaction
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_msg_next    = skid_msg_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push.valid;
                out_msg_next   = push.msg;
            end
        end else if (push.valid) begin
            // hold the new result behind the stalled one
            skid_valid_next = 1'b1;
            skid_msg_next   = push.msg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_msg_reg  <= out_msg_next;
        skid_msg_reg <= skid_msg_next;
    end

    `MRSP_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `MRSP_ASSERT(a_no_push_when_full, aclk, aresetn, skid_valid_reg |-> !push.valid)
    `MRSP_ASSERT_ALWAYS(a_empty_after_reset, aclk, !aresetn |=> (!out_valid_reg && !skid_valid_reg))

endmodule

`default_nettype wire
